// File: hdl/mv_predictor_candidate_list_macros.svh
// Assertion macros shared by the candidate list RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef MV_PREDICTOR_CANDIDATE_LIST_MACROS_SVH
`define MV_PREDICTOR_CANDIDATE_LIST_MACROS_SVH

// Condition that must hold at every edge outside reset
`define MVPCL_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Same-cycle implication
`define MVPCL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define MVPCL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/mvpcl_pkg.sv
// Types, constants and list helpers for the motion vector predictor list.
// Used by every module of the block; depends on nothing.
package mvpcl_pkg;

    localparam int MV_FRAC_BITS = 2;
    localparam int MAX_CANDS    = 4;
    localparam int NUM_NB       = 6;
    localparam int IDX_W        = $clog2(MAX_CANDS);
    localparam int CNT_W        = $clog2(MAX_CANDS + 1);
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 14;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = 14'd1920;
    localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 14'd1080;

    // neighbour positions in the neighbour array
    localparam int NB_LEFT        = 0;
    localparam int NB_ABOVE       = 1;
    localparam int NB_ABOVE_LEFT  = 2;
    localparam int NB_ABOVE_RIGHT = 3;
    localparam int NB_TEMPORAL    = 4;
    localparam int NB_BELOW_LEFT  = 5;

    typedef struct packed {
        logic              v;
        logic signed [15:0] x;
        logic signed [15:0] y;
    } mv_t;

    typedef mv_t [MAX_CANDS-1:0] mv_list_t;
    typedef logic [CNT_W-1:0]    cnt_t;

    typedef struct packed {
        mv_list_t slot;
        cnt_t     cnt;
    } cand_list_t;

    // input register contents
    typedef struct packed {
        logic [12:0]          bx;
        logic [12:0]          by;
        logic [8:0]           bw;
        logic [8:0]           bh;
        mv_t [NUM_NB-1:0]     nb;
    } blk_t;

    typedef struct packed {
        logic signed [16:0] wx;
        logic signed [16:0] wy;
    } wpel_t;

    // clipped geometry and whole-pixel vectors
    typedef struct packed {
        logic [12:0]          bx;
        logic [12:0]          by;
        logic signed [15:0]   bw;
        logic signed [15:0]   bh;
        mv_t [NUM_NB-1:0]     nb;
        wpel_t [NUM_NB-1:0]   wp;
    } geom_t;

    // neighbours with their in-frame flags
    typedef struct packed {
        mv_t [NUM_NB-1:0]   nb;
        logic [NUM_NB-1:0]  ok;
    } chk_t;

    // list after the spatial and median rounds, plus pending fills
    typedef struct packed {
        cand_list_t lst;
        mv_t        tmp;
        mv_t        bl;
    } part_t;

    function automatic logic mv_equal(input mv_t a, input mv_t b);
        return (a.x == b.x) && (a.y == b.y);
    endfunction

    // Put a candidate into the first empty slot of a compacted list,
    // unless it is invalid, a duplicate, or the list is full.
    function automatic cand_list_t list_append(input cand_list_t l, input mv_t c);
        cand_list_t r;
        logic       dup;
        r   = l;
        dup = 1'b0;
        for (int j = 0; j < MAX_CANDS; j++)
        begin
            if (l.slot[j].v && mv_equal(l.slot[j], c))
            begin
                dup = 1'b1;
            end
        end
        if (c.v && !dup && (l.cnt < CNT_W'(MAX_CANDS)))
        begin
            r.slot[l.cnt[IDX_W-1:0]] = c;
            r.cnt                    = l.cnt + cnt_t'(1);
        end
        return r;
    endfunction

endpackage

// File: hdl/mvpcl_check.sv
// Frame test stages: clip block size, truncate vectors to whole pixels,
// then flag each neighbour whose reference block stays in the frame. Uses mvpcl_pkg.
module mvpcl_check (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  mvpcl_pkg::blk_t                    in_blk,
    input  logic [mvpcl_pkg::CFG_DATA_W-1:0]   frame_width,
    input  logic [mvpcl_pkg::CFG_DATA_W-1:0]   frame_height,
    output logic                               out_valid,
    input  logic                               out_stall,
    output mvpcl_pkg::chk_t                    out_chk
);
    import mvpcl_pkg::*;

    logic   geo_v_reg;
    geom_t  geo_reg;
    geom_t  geo_next;
    logic   chk_v_reg;
    chk_t   chk_reg;
    chk_t   chk_next;
    logic   adv_geo;
    logic   adv_chk;

    logic [13:0]        x_end;
    logic [13:0]        y_end;
    logic signed [19:0] rx  [NUM_NB];
    logic signed [19:0] ry  [NUM_NB];
    logic signed [19:0] rxe [NUM_NB];
    logic signed [19:0] rye [NUM_NB];
    logic signed [19:0] fw_s;
    logic signed [19:0] fh_s;

    // truncate a quarter-pel value toward zero to whole pixels
    function automatic logic signed [16:0] whole_pel(input logic signed [15:0] q);
        logic [16:0] mag;
        logic [16:0] sh;
        mag = q[15] ? (17'd0 - {q[15], q}) : {1'b0, q};
        sh  = mag >> MV_FRAC_BITS;
        return q[15] ? $signed(17'd0 - sh) : $signed(sh);
    endfunction

    // clip size at the frame edge and truncate vectors
    always_comb
    begin
        x_end       = {1'b0, in_blk.bx} + {5'b0, in_blk.bw};
        y_end       = {1'b0, in_blk.by} + {5'b0, in_blk.bh};
        geo_next.bx = in_blk.bx;
        geo_next.by = in_blk.by;
        geo_next.nb = in_blk.nb;
        geo_next.bw = (x_end > frame_width)
                    ? ($signed({2'b0, frame_width}) - $signed({3'b0, in_blk.bx}))
                    : $signed({7'b0, in_blk.bw});
        geo_next.bh = (y_end > frame_height)
                    ? ($signed({2'b0, frame_height}) - $signed({3'b0, in_blk.by}))
                    : $signed({7'b0, in_blk.bh});
        for (int i = 0; i < NUM_NB; i++)
        begin
            geo_next.wp[i].wx = whole_pel(in_blk.nb[i].x);
            geo_next.wp[i].wy = whole_pel(in_blk.nb[i].y);
        end
    end

    // test each reference block against the frame
    always_comb
    begin
        fw_s        = $signed({6'b0, frame_width});
        fh_s        = $signed({6'b0, frame_height});
        chk_next.nb = geo_reg.nb;
        for (int i = 0; i < NUM_NB; i++)
        begin
            rx[i]  = $signed({7'b0, geo_reg.bx}) - 20'(geo_reg.wp[i].wx);
            ry[i]  = $signed({7'b0, geo_reg.by}) - 20'(geo_reg.wp[i].wy);
            rxe[i] = rx[i] + 20'(geo_reg.bw);
            rye[i] = ry[i] + 20'(geo_reg.bh);
            chk_next.ok[i] = !((rx[i] < 0) || (rxe[i] > fw_s)
                            || (ry[i] < 0) || (rye[i] > fh_s));
        end
    end

    // stall chain: a stage advances when empty or when its consumer takes
    assign adv_chk  = !chk_v_reg || !out_stall;
    assign adv_geo  = !geo_v_reg || adv_chk;
    assign in_stall = !adv_geo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geo_v_reg <= 1'b0;
            chk_v_reg <= 1'b0;
        end
        else
        begin
            if (adv_geo)
            begin
                geo_v_reg <= in_valid;
            end
            if (adv_chk)
            begin
                chk_v_reg <= geo_v_reg;
            end
        end
    end

    // hold payload unless the stage advances with a beat
    always_ff @(posedge clk)
    begin
        if (adv_geo && in_valid)
        begin
            geo_reg <= geo_next;
        end
        if (adv_chk && geo_v_reg)
        begin
            chk_reg <= chk_next;
        end
    end

    assign out_valid = chk_v_reg;
    assign out_chk   = chk_reg;

endmodule

// File: hdl/mvpcl_list.sv
// Spatial round: seed slots from left, above, above-left (above-right when
// one is missing), drop out-of-frame and duplicates, compact, add the median of three.
module mvpcl_list (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  mvpcl_pkg::chk_t     in_chk,
    output logic                out_valid,
    input  logic                out_stall,
    output mvpcl_pkg::part_t    out_part
);
    import mvpcl_pkg::*;

    logic                   v_reg;
    part_t                  part_reg;
    part_t                  part_next;
    logic                   adv;
    mv_list_t               seed;
    logic [MAX_CANDS-1:0]   live;
    logic [MAX_CANDS-1:0]   keep;
    cand_list_t             comp;
    mv_t                    med;

    function automatic logic signed [15:0] med3(
        input logic signed [15:0] a,
        input logic signed [15:0] b,
        input logic signed [15:0] c
    );
        logic signed [15:0] lo;
        logic signed [15:0] hi;
        logic signed [15:0] m;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        m  = (hi < c) ? hi : c;
        return (lo > m) ? lo : m;
    endfunction

    always_comb
    begin
        // seed slots; above-right only when the first three are not all present
        seed[0] = in_chk.nb[NB_LEFT];
        seed[1] = in_chk.nb[NB_ABOVE];
        seed[2] = in_chk.nb[NB_ABOVE_LEFT];
        seed[3] = in_chk.nb[NB_ABOVE_RIGHT];
        live[0] = in_chk.nb[NB_LEFT].v && in_chk.ok[NB_LEFT];
        live[1] = in_chk.nb[NB_ABOVE].v && in_chk.ok[NB_ABOVE];
        live[2] = in_chk.nb[NB_ABOVE_LEFT].v && in_chk.ok[NB_ABOVE_LEFT];
        live[3] = !(in_chk.nb[NB_LEFT].v && in_chk.nb[NB_ABOVE].v
                    && in_chk.nb[NB_ABOVE_LEFT].v)
                  && in_chk.nb[NB_ABOVE_RIGHT].v && in_chk.ok[NB_ABOVE_RIGHT];

        // drop later duplicates of earlier live entries
        for (int i = 0; i < MAX_CANDS; i++)
        begin
            keep[i] = live[i];
            for (int k = 0; k < i; k++)
            begin
                if (live[k] && mv_equal(seed[i], seed[k]))
                begin
                    keep[i] = 1'b0;
                end
            end
        end

        // compact survivors to the front
        comp.slot = '0;
        comp.cnt  = '0;
        for (int i = 0; i < MAX_CANDS; i++)
        begin
            if (keep[i])
            begin
                comp.slot[comp.cnt[IDX_W-1:0]]   = seed[i];
                comp.slot[comp.cnt[IDX_W-1:0]].v = 1'b1;
                comp.cnt                         = comp.cnt + cnt_t'(1);
            end
        end

        // median of three full slots always lands in frame
        med.v = 1'b1;
        med.x = med3(comp.slot[0].x, comp.slot[1].x, comp.slot[2].x);
        med.y = med3(comp.slot[0].y, comp.slot[1].y, comp.slot[2].y);
        part_next.lst = (comp.cnt >= cnt_t'(3)) ? list_append(comp, med) : comp;

        // carry the fill candidates with their frame test folded in
        part_next.tmp   = in_chk.nb[NB_TEMPORAL];
        part_next.tmp.v = in_chk.nb[NB_TEMPORAL].v && in_chk.ok[NB_TEMPORAL];
        part_next.bl    = in_chk.nb[NB_BELOW_LEFT];
        part_next.bl.v  = in_chk.nb[NB_BELOW_LEFT].v && in_chk.ok[NB_BELOW_LEFT];
    end

    assign adv      = !v_reg || !out_stall;
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg <= in_valid;
        end
    end

    // load the stage on an incoming beat
    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            part_reg <= part_next;
        end
    end

    assign out_valid = v_reg;
    assign out_part  = part_reg;

endmodule

// File: hdl/mvpcl_fill.sv
// Fill round and result register: temporal then below-left take the first
// empty slot. Uses mvpcl_pkg and the assertion macros.
`include "mv_predictor_candidate_list_macros.svh"

module mvpcl_fill (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  mvpcl_pkg::part_t           in_part,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [32:0]                pred0,
    output logic [32:0]                pred1,
    output logic [32:0]                pred2,
    output logic [32:0]                pred3,
    output logic [mvpcl_pkg::CNT_W-1:0] pred_count
);
    import mvpcl_pkg::*;

    logic                   v_reg;
    cand_list_t             res_reg;
    cand_list_t             res_next;
    logic                   adv;
    logic [MAX_CANDS-1:0]   res_v;
    logic                   res_dup;

    // temporal first, then below-left
    assign res_next = list_append(list_append(in_part.lst, in_part.tmp), in_part.bl);

    assign adv      = !v_reg || !out_stall;
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg <= in_valid;
        end
    end

    // hold the result until taken
    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            res_reg <= res_next;
        end
    end

    // empty slots drive all zero
    assign pred0      = res_reg.slot[0].v ? 33'(res_reg.slot[0]) : '0;
    assign pred1      = res_reg.slot[1].v ? 33'(res_reg.slot[1]) : '0;
    assign pred2      = res_reg.slot[2].v ? 33'(res_reg.slot[2]) : '0;
    assign pred3      = res_reg.slot[3].v ? 33'(res_reg.slot[3]) : '0;
    assign pred_count = res_reg.cnt;
    assign out_valid  = v_reg;

    // result flags for checking
    always_comb
    begin
        res_dup = 1'b0;
        for (int i = 0; i < MAX_CANDS; i++)
        begin
            res_v[i] = res_reg.slot[i].v;
            for (int k = 0; k < i; k++)
            begin
                if (res_reg.slot[i].v && res_reg.slot[k].v
                    && mv_equal(res_reg.slot[i], res_reg.slot[k]))
                begin
                    res_dup = 1'b1;
                end
            end
        end
    end

    `MVPCL_ASSERT_IMP(a_count_match, out_valid, pred_count == CNT_W'($countones(res_v)), "pred_count disagrees with valid slots")
    `MVPCL_ASSERT_IMP(a_compacted, out_valid, (res_v[MAX_CANDS-1:1] & ~res_v[MAX_CANDS-2:0]) == '0, "hole in predictor list")
    `MVPCL_ASSERT_IMP(a_no_dup, out_valid, !res_dup, "duplicate predictor in list")

endmodule

// File: hdl/mv_predictor_candidate_list.sv
// Pipeline: a beat accepted at the input passes through the input, clip, frame test,
// spatial and fill registers before its result shows on the outputs.
// Throughput: one block per cycle unless stalled; each stage advances when empty
// or drained, so a stalled output holds only the stages behind it that are full.
// Reset clears all stage valids and sets the frame size to 1920 x 1080;
// payload registers are not reset.
`include "mv_predictor_candidate_list_macros.svh"

module mv_predictor_candidate_list (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [12:0]                         block_x,
    input  logic [12:0]                         block_y,
    input  logic [8:0]                          block_w,
    input  logic [8:0]                          block_h,
    input  logic [32:0]                         cand_left,
    input  logic [32:0]                         cand_above,
    input  logic [32:0]                         cand_above_left,
    input  logic [32:0]                         cand_above_right,
    input  logic [32:0]                         cand_temporal,
    input  logic [32:0]                         cand_below_left,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [32:0]                         pred0,
    output logic [32:0]                         pred1,
    output logic [32:0]                         pred2,
    output logic [32:0]                         pred3,
    output logic [mvpcl_pkg::CNT_W-1:0]         pred_count,
    input  logic                                cfg_we,
    input  logic [mvpcl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mvpcl_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import mvpcl_pkg::*;

    logic [CFG_DATA_W-1:0] frame_width_reg;
    logic [CFG_DATA_W-1:0] frame_height_reg;
    logic                  in_v_reg;
    blk_t                  in_blk_reg;
    blk_t                  in_blk_next;
    logic                  adv_in;
    logic                  chk_stall;
    logic                  chk_valid;
    chk_t                  chk_data;
    logic                  list_stall;
    logic                  list_valid;
    part_t                 list_data;
    logic                  fill_stall;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // gather the input beat
    always_comb
    begin
        in_blk_next.bx                 = block_x;
        in_blk_next.by                 = block_y;
        in_blk_next.bw                 = block_w;
        in_blk_next.bh                 = block_h;
        in_blk_next.nb[NB_LEFT]        = mv_t'(cand_left);
        in_blk_next.nb[NB_ABOVE]       = mv_t'(cand_above);
        in_blk_next.nb[NB_ABOVE_LEFT]  = mv_t'(cand_above_left);
        in_blk_next.nb[NB_ABOVE_RIGHT] = mv_t'(cand_above_right);
        in_blk_next.nb[NB_TEMPORAL]    = mv_t'(cand_temporal);
        in_blk_next.nb[NB_BELOW_LEFT]  = mv_t'(cand_below_left);
    end

    assign adv_in   = !in_v_reg || !chk_stall;
    assign in_stall = !adv_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else if (adv_in)
        begin
            in_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_in && in_valid)
        begin
            in_blk_reg <= in_blk_next;
        end
    end

    mvpcl_check u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_v_reg),
        .in_stall     (chk_stall),
        .in_blk       (in_blk_reg),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .out_valid    (chk_valid),
        .out_stall    (list_stall),
        .out_chk      (chk_data)
    );

    mvpcl_list u_list (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chk_valid),
        .in_stall  (list_stall),
        .in_chk    (chk_data),
        .out_valid (list_valid),
        .out_stall (fill_stall),
        .out_part  (list_data)
    );

    mvpcl_fill u_fill (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (list_valid),
        .in_stall   (fill_stall),
        .in_part    (list_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pred0      (pred0),
        .pred1      (pred1),
        .pred2      (pred2),
        .pred3      (pred3),
        .pred_count (pred_count)
    );

    `MVPCL_ASSERT_NEXT(a_width_write, cfg_we && (cfg_index == REG_FRAME_WIDTH), frame_width_reg == $past(cfg_data), "frame width write lost")
    `MVPCL_ASSERT_NEXT(a_height_write, cfg_we && (cfg_index == REG_FRAME_HEIGHT), frame_height_reg == $past(cfg_data), "frame height write lost")
    `MVPCL_ASSERT_NEXT(a_width_isolated, cfg_we && (cfg_index == REG_FRAME_WIDTH), $stable(frame_height_reg), "width write disturbed height")

endmodule

// File: tb/tb_mv_predictor_candidate_list.sv
// Self-checking testbench for the motion vector predictor candidate list.
// Drives blocks against a local model of the list build and checks each list.
// Depends on mvpcl_pkg and mv_predictor_candidate_list.
module tb_mv_predictor_candidate_list;
    timeunit 1ns;
    timeprecision 1ps;

    import mvpcl_pkg::*;

    localparam int NUM_PHASES  = 8;
    localparam int PHASE_ITEMS = 225;
    // frame sizes per phase; a negative entry means a random size
    localparam int PHASE_FW [NUM_PHASES] = '{1920, 1, 8192, 0, 16383, 64, -1, 352};
    localparam int PHASE_FH [NUM_PHASES] = '{1080, 8192, 1, 16383, 0, 48, -1, 288};

    typedef struct packed {
        logic [MAX_CANDS-1:0][32:0] pred;
        cnt_t                       count;
    } cand_result_t;

    typedef struct {
        blk_t         blk;
        bit           typed;
        cand_result_t want;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [12:0] block_x = '0;
    logic [12:0] block_y = '0;
    logic [8:0]  block_w = '0;
    logic [8:0]  block_h = '0;
    logic [32:0] cand_left = '0;
    logic [32:0] cand_above = '0;
    logic [32:0] cand_above_left = '0;
    logic [32:0] cand_above_right = '0;
    logic [32:0] cand_temporal = '0;
    logic [32:0] cand_below_left = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [32:0] pred0;
    logic [32:0] pred1;
    logic [32:0] pred2;
    logic [32:0] pred3;
    logic [CNT_W-1:0]      pred_count;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    cand_result_t lists_due [$];
    int           failures = 0;
    int           frame_w = 1920;
    int           frame_h = 1080;
    int           idle_pct = 0;
    int           stall_pct = 0;
    int           stall_left = 0;
    logic [MAX_CANDS-1:0][32:0] seen_preds;
    cand_result_t seen_want;

    mv_predictor_candidate_list dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .block_x          (block_x),
        .block_y          (block_y),
        .block_w          (block_w),
        .block_h          (block_h),
        .cand_left        (cand_left),
        .cand_above       (cand_above),
        .cand_above_left  (cand_above_left),
        .cand_above_right (cand_above_right),
        .cand_temporal    (cand_temporal),
        .cand_below_left  (cand_below_left),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .pred0            (pred0),
        .pred1            (pred1),
        .pred2            (pred2),
        .pred3            (pred3),
        .pred_count       (pred_count),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // ---------------------------------------------------------------- list model

    // whole-pixel part of a quarter-pel component, truncated toward zero
    function automatic int pel_part(logic signed [15:0] q);
        int qi;
        qi = q;
        if (qi < 0)
            return -((-qi) >>> MV_FRAC_BITS);
        return qi >>> MV_FRAC_BITS;
    endfunction

    function automatic logic signed [15:0] median3(logic signed [15:0] a,
                                                   logic signed [15:0] b,
                                                   logic signed [15:0] c);
        logic signed [15:0] lo;
        logic signed [15:0] hi;
        logic signed [15:0] m;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        m  = (hi < c) ? hi : c;
        return (lo > m) ? lo : m;
    endfunction

    // drop out-of-frame candidates and later duplicates, then compact
    function automatic mv_list_t tidy_cands(mv_list_t s, int bx, int by, int bw, int bh,
                                            int fw, int fh);
        mv_list_t             packed_list;
        logic [MAX_CANDS-1:0] live;
        int                   n;
        int                   rx;
        int                   ry;
        packed_list = '0;
        n = 0;
        for (int i = 0; i < MAX_CANDS; i++)
        begin
            if (s[i].v)
            begin
                rx = bx - pel_part(s[i].x);
                ry = by - pel_part(s[i].y);
                if (rx < 0 || rx + bw > fw || ry < 0 || ry + bh > fh)
                    s[i].v = 1'b0;
            end
            live[i] = s[i].v;
        end
        for (int i = 1; i < MAX_CANDS; i++)
            for (int k = 0; k < i; k++)
                if (live[i] && live[k] && s[i].x == s[k].x && s[i].y == s[k].y)
                    s[i].v = 1'b0;
        for (int i = 0; i < MAX_CANDS; i++)
        begin
            if (s[i].v)
            begin
                packed_list[n] = s[i];
                n++;
            end
        end
        return packed_list;
    endfunction

    function automatic mv_list_t fill_gap(mv_list_t s, mv_t c);
        bit done;
        done = 1'b0;
        for (int i = 0; i < MAX_CANDS; i++)
        begin
            if (!done && !s[i].v)
            begin
                if (c.v)
                    s[i] = c;
                done = 1'b1;
            end
        end
        return s;
    endfunction

    function automatic cand_result_t predict_cand_list(blk_t b, int fw, int fh);
        mv_list_t     s;
        cand_result_t r;
        int           bx;
        int           by;
        int           bw;
        int           bh;
        int           n;
        bx = b.bx;
        by = b.by;
        bw = b.bw;
        bh = b.bh;
        // clip the block at the frame edge; may go to zero or negative
        if (bx + bw > fw)
            bw = fw - bx;
        if (by + bh > fh)
            bh = fh - by;
        s[0] = b.nb[NB_LEFT];
        s[1] = b.nb[NB_ABOVE];
        s[2] = b.nb[NB_ABOVE_LEFT];
        s[3] = (s[0].v && s[1].v && s[2].v) ? mv_t'('0) : b.nb[NB_ABOVE_RIGHT];
        s = tidy_cands(s, bx, by, bw, bh, fw, fh);
        if (s[0].v && s[1].v && s[2].v)
        begin
            s[3].v = 1'b1;
            s[3].x = median3(s[0].x, s[1].x, s[2].x);
            s[3].y = median3(s[0].y, s[1].y, s[2].y);
        end
        s = tidy_cands(s, bx, by, bw, bh, fw, fh);
        s = tidy_cands(fill_gap(s, b.nb[NB_TEMPORAL]), bx, by, bw, bh, fw, fh);
        s = tidy_cands(fill_gap(s, b.nb[NB_BELOW_LEFT]), bx, by, bw, bh, fw, fh);
        n = 0;
        for (int i = 0; i < MAX_CANDS; i++)
        begin
            r.pred[i] = s[i];
            if (s[i].v)
                n++;
        end
        r.count = cnt_t'(n);
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic mv_t vec(bit v, int x, int y);
        mv_t m;
        m.v = v;
        m.x = 16'(x);
        m.y = 16'(y);
        return m;
    endfunction

    function automatic dir_row_t row(int bx, int by, int bw, int bh, mv_t l, mv_t a,
                                     mv_t al, mv_t ar, mv_t t, mv_t bl);
        dir_row_t r;
        r.blk.bx = 13'(bx);
        r.blk.by = 13'(by);
        r.blk.bw = 9'(bw);
        r.blk.bh = 9'(bh);
        r.blk.nb[NB_LEFT]        = l;
        r.blk.nb[NB_ABOVE]       = a;
        r.blk.nb[NB_ABOVE_LEFT]  = al;
        r.blk.nb[NB_ABOVE_RIGHT] = ar;
        r.blk.nb[NB_TEMPORAL]    = t;
        r.blk.nb[NB_BELOW_LEFT]  = bl;
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic dir_row_t pinned(dir_row_t r, cand_result_t want);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    // component whose reference lands near or across the frame edges
    function automatic logic [15:0] pick_comp(int b, int ew, int f);
        int lim;
        int r;
        int wp;
        int frac;
        lim = f - ew;
        if (lim < 0 || $urandom_range(0, 15) == 0)
            return 16'($urandom);
        case ($urandom_range(0, 9))
            0: r = 0;
            1: r = lim;
            2: r = -1;
            3: r = lim + 1;
            default: r = $urandom_range(0, lim);
        endcase
        wp = b - r;
        if (wp > 8191)
            wp = 8191;
        if (wp < -8191)
            wp = -8191;
        frac = $urandom_range(0, (1 << MV_FRAC_BITS) - 1);
        if (wp < 0 || (wp == 0 && $urandom_range(0, 1) == 1))
            frac = -frac;
        return 16'(wp * (1 << MV_FRAC_BITS) + frac);
    endfunction

    function automatic blk_t random_block(int fw, int fh);
        blk_t b;
        mv_t  pool [3];
        int   ew;
        int   eh;
        int   pick;
        // plain noise on every field
        if ($urandom_range(0, 3) == 0)
        begin
            b.bx = 13'($urandom);
            b.by = 13'($urandom);
            b.bw = 9'($urandom);
            b.bh = 9'($urandom);
            for (int i = 0; i < NUM_NB; i++)
                b.nb[i] = {1'($urandom_range(0, 1)), $urandom};
            return b;
        end
        b.bx = (fw > 0) ? 13'($urandom_range(0, ((fw > 8192) ? 8192 : fw) - 1)) : 13'($urandom);
        b.by = (fh > 0) ? 13'($urandom_range(0, ((fh > 8192) ? 8192 : fh) - 1)) : 13'($urandom);
        b.bw = ($urandom_range(0, 4) == 0) ? 9'($urandom) : 9'($urandom_range(1, 64));
        b.bh = ($urandom_range(0, 4) == 0) ? 9'($urandom) : 9'($urandom_range(1, 64));
        ew = (int'(b.bx) + int'(b.bw) > fw) ? fw - int'(b.bx) : int'(b.bw);
        eh = (int'(b.by) + int'(b.bh) > fh) ? fh - int'(b.by) : int'(b.bh);
        // a small pool of vectors, so duplicates and medians come up often
        for (int p = 0; p < 3; p++)
        begin
            pool[p].v = 1'b1;
            pool[p].x = pick_comp(b.bx, ew, fw);
            pool[p].y = pick_comp(b.by, eh, fh);
        end
        if ($urandom_range(0, 3) == 0)
            pool[2].x = pool[1].x;
        for (int i = 0; i < NUM_NB; i++)
        begin
            pick = $urandom_range(0, 5);
            if (pick < 3)
                b.nb[i] = pool[pick];
            else if (pick < 5)
                b.nb[i] = {1'b1, pick_comp(b.bx, ew, fw), pick_comp(b.by, eh, fh)};
            else
                b.nb[i] = {1'($urandom_range(0, 1)), $urandom};
            if ($urandom_range(0, 6) == 0)
                b.nb[i].v = 1'b0;
        end
        return b;
    endfunction

    // hold the beat until accepted, then queue its expected list
    task automatic send_block(blk_t b, bit typed, cand_result_t want);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid         <= 1'b1;
        block_x          <= b.bx;
        block_y          <= b.by;
        block_w          <= b.bw;
        block_h          <= b.bh;
        cand_left        <= b.nb[NB_LEFT];
        cand_above       <= b.nb[NB_ABOVE];
        cand_above_left  <= b.nb[NB_ABOVE_LEFT];
        cand_above_right <= b.nb[NB_ABOVE_RIGHT];
        cand_temporal    <= b.nb[NB_TEMPORAL];
        cand_below_left  <= b.nb[NB_BELOW_LEFT];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        lists_due.push_back(typed ? want : predict_cand_list(b, frame_w, frame_h));
    endtask

    // write the frame size once the pipeline has drained
    task automatic set_frame(int fw, int fh);
        while (lists_due.size() != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data  <= CFG_DATA_W'(fw);
        @(posedge clk);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_data  <= CFG_DATA_W'(fh);
        @(posedge clk);
        cfg_we  <= 1'b0;
        frame_w = fw;
        frame_h = fh;
    endtask

    initial
    begin
        dir_row_t dir_rows [$];
        mv_t      nil;
        int       fw;
        int       fh;
        nil = '0;
        // nothing valid: empty list
        dir_rows.push_back(pinned(row(0, 0, 16, 16, nil, nil, nil, nil, nil, nil), '0));
        // zero vector at the frame corner: one entry {pred3..pred0, count}
        dir_rows.push_back(pinned(row(0, 0, 16, 16, vec(1, 0, 0), nil, nil, nil, nil, nil),
                                  cand_result_t'({99'h0, 33'h1_0000_0000, 3'd1})));
        // reference one pixel left of the frame: dropped
        dir_rows.push_back(pinned(row(0, 0, 16, 16, vec(1, 4, 0), nil, nil, nil, nil, nil),
                                  '0));
        // invalid vectors carrying payload come out as zeros
        dir_rows.push_back(pinned(row(5, 5, 8, 8, mv_t'(33'h0_1234_5678),
                                      mv_t'(33'h0_ffff_ffff), mv_t'(33'h0_8000_8000),
                                      mv_t'(33'h0_7fff_7fff), mv_t'(33'h0_0004_0004),
                                      mv_t'(33'h0_0001_0001)), '0));
        // three distinct spatial vectors plus their median fill the list
        dir_rows.push_back(row(100, 100, 16, 16, vec(1, -8, 4), vec(1, 12, -4), vec(1, 0, 40),
                               vec(1, 20, 20), vec(1, -3, -3), vec(1, 5, 5)));
        // identical spatial vectors collapse, then temporal and below-left fill
        dir_rows.push_back(row(100, 100, 16, 16, vec(1, 8, 8), vec(1, 8, 8), vec(1, 8, 8),
                               vec(1, 20, 20), vec(1, -4, 4), vec(1, 4, -4)));
        // left missing: above-right is used and lands in slot 2
        dir_rows.push_back(row(64, 64, 8, 8, nil, vec(1, 4, 4), vec(1, -4, -4),
                               vec(1, 16, 0), vec(1, 0, 16), vec(1, 1, 1)));
        // median equals the above vector and is dropped as a duplicate
        dir_rows.push_back(row(50, 50, 8, 8, vec(1, 0, 0), vec(1, 4, 4), vec(1, 8, 8),
                               vec(1, 12, 12), vec(1, -8, -8), vec(1, 2, 2)));
        // temporal invalid, below-left used
        dir_rows.push_back(row(50, 50, 8, 8, vec(1, 0, 0), nil, nil, nil,
                               mv_t'(33'h0_0004_0004), vec(1, -4, 0)));
        // block clipped at the right and bottom edges
        dir_rows.push_back(row(1919, 1079, 256, 256, vec(1, 0, 0), vec(1, -4, 0),
                               vec(1, 3, -3), vec(1, 4, 4), vec(1, 4, 4), vec(1, 0, -4)));
        // block entirely outside the frame: negative clipped size
        dir_rows.push_back(row(8191, 8191, 1, 1, vec(1, 0, 0), vec(1, 32764, 32764),
                               vec(1, -32768, -32768), vec(1, 32767, 0), vec(1, 4, 4),
                               vec(1, 32767, 32767)));
        // extreme fields everywhere
        dir_rows.push_back(row(8191, 8191, 511, 511, mv_t'(33'h1_ffff_ffff),
                               mv_t'(33'h1_7fff_7fff), mv_t'(33'h1_8000_8000),
                               mv_t'(33'h1_8000_7fff), mv_t'(33'h1_0000_0000),
                               mv_t'(33'h1_7fff_8000)));
        dir_rows.push_back(row(0, 0, 511, 511, mv_t'(33'h1_ffff_ffff), vec(1, 0, 0),
                               mv_t'(33'h1_7fff_7fff), vec(1, -1, 1), vec(1, 1, -1),
                               vec(1, 3, 3)));
        // zero-size block
        dir_rows.push_back(row(0, 0, 0, 0, vec(1, 0, 0), vec(1, 3, 0), vec(1, -4, -4),
                               vec(1, 0, 4), vec(1, 8, 0), vec(1, -3, 0)));
        // truncation toward zero of negative quarter-pel values
        dir_rows.push_back(row(0, 0, 8, 8, vec(1, -3, -3), vec(1, 3, 3), vec(1, -4, 0),
                               vec(1, -5, -7), vec(1, -7, -5), vec(1, -1, -2)));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph != 0)
            begin
                fw = (PHASE_FW[ph] < 0) ? $urandom_range(1, 8192) : PHASE_FW[ph];
                fh = (PHASE_FH[ph] < 0) ? $urandom_range(1, 8192) : PHASE_FH[ph];
                set_frame(fw, fh);
            end
            // quiet last phase; elsewhere pick a random idling mix
            if (ph == NUM_PHASES - 1)
            begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            else
            begin
                idle_pct  = $urandom_range(0, 2) * 20;
                stall_pct = $urandom_range(0, 2) * 20;
            end
            if (ph == 0)
                foreach (dir_rows[r])
                    send_block(dir_rows[r].blk, dir_rows[r].typed, dir_rows[r].want);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_block(random_block(frame_w, frame_h), 1'b0, '0);
            in_valid <= 1'b0;
        end

        while (lists_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // ---------------------------------------------------------------- output side

    // stall the output in bursts of random length
    always @(posedge clk)
    begin
        if (!rst_n || stall_pct == 0)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 99) < stall_pct)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 12);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // check each accepted list beat against the oldest expected list
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (lists_due.size() == 0)
            begin
                $error("candidate list beat with no list pending");
                failures++;
            end
            else
            begin
                seen_want  = lists_due.pop_front();
                seen_preds = {pred3, pred2, pred1, pred0};
                for (int i = 0; i < MAX_CANDS; i++)
                begin
                    if (seen_preds[i] !== seen_want.pred[i])
                    begin
                        $error("pred%0d: expected %h, got %h", i, seen_want.pred[i],
                               seen_preds[i]);
                        failures++;
                    end
                end
                if (pred_count !== seen_want.count)
                begin
                    $error("pred_count: expected %0d, got %0d", seen_want.count, pred_count);
                    failures++;
                end
            end
        end
    end

endmodule
